### sv/diagonal_mahalanobis_classifier_macros.svh
// Assertion macros used by the classifier checker.
`ifndef DIAGONAL_MAHALANOBIS_CLASSIFIER_MACROS_SVH
`define DIAGONAL_MAHALANOBIS_CLASSIFIER_MACROS_SVH

// Same-cycle implication, ignored while in reset.
`define DMC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("classifier check failed");

// Next-cycle implication, ignored while in reset.
`define DMC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("classifier check failed");

// Next-cycle implication that also holds through reset.
`define DMC_ASSERT_NXT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("classifier check failed");

`endif

### sv/dmc_pkg.sv
// Shared constants, codes and types of the Mahalanobis classifier.
`timescale 1ns / 1ps
package dmc_pkg;
  localparam int NUM_CLASSES  = 5;
  localparam int NUM_FEATURES = 4;
  localparam int FEAT_W       = 2;
  localparam int CLS_W        = $clog2(NUM_CLASSES);
  localparam int CNT_W        = $clog2(NUM_CLASSES + 1);
  localparam int ENTRIES      = NUM_CLASSES * NUM_FEATURES;
  localparam int ADDR_W       = CLS_W + FEAT_W;
  localparam int MEAN_W       = 40;
  localparam int VAR_W        = 48;
  localparam int DIST_W       = 48;
  localparam int BIAS_W       = 32;
  localparam int MAG_W        = 40;
  localparam int SQ_W         = 80;
  localparam int DIV_W        = 82;
  localparam int CFG_W        = 48;

  localparam logic [DIST_W-1:0] DIST_MAX        = {DIST_W{1'b1}};
  localparam logic [DIST_W-1:0] THRESHOLD_RESET = 48'd870122;
  localparam logic [BIAS_W-1:0] BIAS_RESET      = 32'd131072;

  localparam logic [0:0] REG_THRESHOLD = 1'b0;
  localparam logic [0:0] REG_BIAS      = 1'b1;

  localparam logic [0:0] MODE_LOAD     = 1'b0;
  localparam logic [0:0] MODE_CLASSIFY = 1'b1;

  localparam logic [1:0] VERDICT_UNKNOWN    = 2'd0;
  localparam logic [1:0] VERDICT_RECOGNIZED = 2'd1;
  localparam logic [1:0] VERDICT_AMBIGUOUS  = 2'd2;

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_READ, SEQ_START, SEQ_WAIT, SEQ_CLASS, SEQ_FINISH
  } seq_state_t;

  typedef enum logic [2:0] {
    TU_IDLE, TU_SQUARE, TU_SCALE, TU_CHECK, TU_DIVIDE, TU_DONE
  } tu_state_t;

  typedef struct packed {
    logic                     start;
    logic signed [MEAN_W-1:0] feature;
  } tu_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } tu_status_t;

  typedef struct packed {
    logic [MEAN_W-1:0] mean;
    logic [VAR_W-1:0]  variance;
  } entry_t;
endpackage

### sv/dmc_channels.sv
// Request and result channel interfaces of the classifier.
`timescale 1ns / 1ps
interface dmc_req_if;
  logic               valid;
  logic               ready;
  logic [0:0]         mode;
  logic [2:0]         class_index;
  logic [1:0]         feature_index;
  logic signed [39:0] mean_value;
  logic [47:0]        variance_value;
  logic signed [39:0] feature_area;
  logic signed [39:0] feature_hu_first;
  logic signed [39:0] feature_hu_second;
  logic signed [39:0] feature_perimeter;
  modport source (output valid, mode, class_index, feature_index, mean_value,
                  variance_value, feature_area, feature_hu_first, feature_hu_second,
                  feature_perimeter, input ready);
  modport sink (input valid, mode, class_index, feature_index, mean_value,
                variance_value, feature_area, feature_hu_first, feature_hu_second,
                feature_perimeter, output ready);
endinterface

interface dmc_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [2:0]  match_count;
  logic [2:0]  best_class;
  logic [47:0] best_distance;
  modport source (output valid, verdict, match_count, best_class, best_distance,
                  input ready);
  modport sink (input valid, verdict, match_count, best_class, best_distance,
                output ready);
endinterface

### sv/diagonal_mahalanobis_classifier.sv
// Top level: class table, term sequencer, class scoring and result register.
// A load is written at its accepting edge; a classify result is scored over 20 terms,
// each made by the 10-step square, 12-step divisor scale and 48-step divide, then summed
// per class; a saturated term skips its divide. A new request is taken only once the
// previous classify has reached the result register; one load per cycle while idle.
// Reset: rst (synchronous) idles the sequencer, drops the result, restores threshold and bias.
`timescale 1ns / 1ps
module diagonal_mahalanobis_classifier import dmc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  dmc_req_if.sink           request,
  dmc_rsp_if.source         result,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);
  seq_state_t state, state_next;

  logic [DIST_W-1:0]  threshold;
  logic [BIAS_W-1:0]  bias;
  logic [CLS_W-1:0]   cls;
  logic [FEAT_W-1:0]  feat;
  logic [DIST_W-1:0]  sum, best;
  logic [CLS_W-1:0]   best_cls;
  logic [CNT_W-1:0]   count;
  logic signed [MEAN_W-1:0] x_area, x_hu1, x_hu2, x_per;

  logic               req_take;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  entry_t             ram_wdata, ram_rdata;
  tu_cmd_t            tu_cmd;
  tu_status_t         tu_stat;
  logic [DIST_W-1:0]  term;
  logic [DIST_W:0]    sum_wide;
  logic               out_free;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
      bias      <= BIAS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: threshold <= cfg_data;
        REG_BIAS:      bias      <= cfg_data[BIAS_W-1:0];
        default:       ;
      endcase
    end
  end

  assign req_take  = request.valid && request.ready;
  assign ram_we    = req_take && (request.mode == MODE_LOAD)
                     && (int'(request.class_index) < NUM_CLASSES);
  assign ram_waddr = {CLS_W'(request.class_index), request.feature_index};
  assign ram_wdata = '{mean: request.mean_value, variance: request.variance_value};

  dmc_table_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr ({cls, feat}),
    .rdata (ram_rdata)
  );

  dmc_term_unit u_term (
    .clk    (clk),
    .rst    (rst),
    .cmd    (tu_cmd),
    .entry  (ram_rdata),
    .bias   (bias),
    .status (tu_stat),
    .term   (term)
  );

  assign out_free = !result.valid || result.ready;
  assign sum_wide = {1'b0, sum} + {1'b0, term};

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      SEQ_IDLE:   if (req_take && request.mode == MODE_CLASSIFY) state_next = SEQ_READ;
      SEQ_READ:   state_next = SEQ_START;
      SEQ_START:  state_next = SEQ_WAIT;
      SEQ_WAIT: begin
        if (tu_stat.done) begin
          state_next = (feat == FEAT_W'(NUM_FEATURES - 1)) ? SEQ_CLASS : SEQ_READ;
        end
      end
      SEQ_CLASS:  state_next = (cls == CLS_W'(NUM_CLASSES - 1)) ? SEQ_FINISH : SEQ_READ;
      SEQ_FINISH: if (out_free) state_next = SEQ_IDLE;
      default:    state_next = SEQ_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    request.ready = (state == SEQ_IDLE);
    tu_cmd.start  = (state == SEQ_START);
    unique case (feat)
      2'd0:    tu_cmd.feature = x_area;
      2'd1:    tu_cmd.feature = x_hu1;
      2'd2:    tu_cmd.feature = x_hu2;
      default: tu_cmd.feature = x_per;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Accumulate terms and score classes
  always_ff @(posedge clk) begin
    case (state)
      SEQ_IDLE: begin
        if (req_take) begin
          x_area   <= request.feature_area;
          x_hu1    <= request.feature_hu_first;
          x_hu2    <= request.feature_hu_second;
          x_per    <= request.feature_perimeter;
          cls      <= '0;
          feat     <= '0;
          sum      <= '0;
          best     <= threshold;
          best_cls <= '0;
          count    <= '0;
        end
      end
      SEQ_WAIT: begin
        if (tu_stat.done) begin
          sum <= sum_wide[DIST_W] ? DIST_MAX : sum_wide[DIST_W-1:0];
          if (feat != FEAT_W'(NUM_FEATURES - 1)) begin
            feat <= feat + 1'b1;
          end
        end
      end
      SEQ_CLASS: begin
        if (sum < threshold) begin
          count <= count + 1'b1;
          if (sum < best) begin
            best     <= sum;
            best_cls <= cls;
          end
        end
        sum  <= '0;
        feat <= '0;
        if (cls != CLS_W'(NUM_CLASSES - 1)) begin
          cls <= cls + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == SEQ_FINISH && out_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == SEQ_FINISH && out_free) begin
      result.verdict       <= (count == '0) ? VERDICT_UNKNOWN :
                              (count == CNT_W'(1)) ? VERDICT_RECOGNIZED : VERDICT_AMBIGUOUS;
      result.match_count   <= 3'(count);
      result.best_class    <= 3'(best_cls);
      result.best_distance <= best;
    end
  end
endmodule

### sv/dmc_table_ram.sv
// Single-port-write, registered-read RAM for the class table.
`timescale 1ns / 1ps
module dmc_table_ram #(
  parameter int WIDTH = 88,
  parameter int DEPTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

### sv/dmc_term_unit.sv
// Sequential term unit: square, divisor scale and restoring divide.
`timescale 1ns / 1ps
module dmc_term_unit import dmc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  tu_cmd_t                  cmd,
  input  entry_t                   entry,
  input  logic [BIAS_W-1:0]        bias,
  output tu_status_t               status,
  output logic [DIST_W-1:0]        term
);
  tu_state_t state, state_next;

  logic [DIV_W-1:0]   acc, mc, dv;
  logic [VAR_W-1:0]   mp;
  logic [VAR_W-1:0]   var_q;
  logic [BIAS_W-1:0]  bias_q;
  logic [3:0]         step;
  logic [5:0]         dcnt;
  logic [SQ_W-1:0]    sq;
  logic [DIV_W:0]     rem;
  logic [DIST_W-1:0]  lo;
  logic [DIST_W-1:0]  quo;

  logic signed [MEAN_W:0] diff;
  logic [MAG_W-1:0]       mag;
  logic [DIV_W-1:0]       acc_next;
  logic [DIV_W:0]         trial;
  logic                   sat;

  // Magnitude of the feature difference
  always_comb begin
    diff = {cmd.feature[MEAN_W-1], cmd.feature} - {entry.mean[MEAN_W-1], entry.mean};
    mag  = diff[MEAN_W] ? MAG_W'(-diff) : MAG_W'(diff);
  end

  // Shift-add step, one nibble of the multiplier per cycle
  assign acc_next = acc + mc * DIV_W'(mp[3:0]);
  assign trial    = {rem[DIV_W-1:0], lo[DIST_W-1]};
  assign sat      = {{(DIV_W-SQ_W+32){1'b0}}, sq[SQ_W-1:32]} >= dv;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      TU_IDLE:   if (cmd.start) state_next = TU_SQUARE;
      TU_SQUARE: if (step == 4'd9) state_next = TU_SCALE;
      TU_SCALE:  if (step == 4'd11) state_next = TU_CHECK;
      TU_CHECK:  state_next = sat ? TU_DONE : TU_DIVIDE;
      TU_DIVIDE: if (dcnt == 6'(DIST_W - 1)) state_next = TU_DONE;
      TU_DONE:   state_next = TU_IDLE;
      default:   state_next = TU_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    status.busy = (state != TU_IDLE);
    status.done = (state == TU_DONE);
    term        = quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= TU_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state)
      TU_IDLE: begin
        if (cmd.start) begin
          mc     <= DIV_W'(mag);
          mp     <= VAR_W'(mag);
          acc    <= '0;
          step   <= '0;
          var_q  <= entry.variance;
          bias_q <= bias;
        end
      end
      TU_SQUARE: begin
        step <= step + 4'd1;
        if (step == 4'd9) begin
          sq   <= acc_next[SQ_W-1:0];
          mc   <= DIV_W'({1'b0, bias_q} + 33'h1_0000);
          mp   <= var_q;
          acc  <= DIV_W'({bias_q, 16'h0000});
          step <= '0;
        end else begin
          acc <= acc_next;
          mc  <= mc << 4;
          mp  <= mp >> 4;
        end
      end
      TU_SCALE: begin
        acc  <= acc_next;
        mc   <= mc << 4;
        mp   <= mp >> 4;
        step <= step + 4'd1;
        if (step == 4'd11) begin
          dv <= acc_next;
        end
      end
      TU_CHECK: begin
        rem  <= (DIV_W + 1)'(sq[SQ_W-1:32]);
        lo   <= {sq[31:0], 16'h0000};
        dcnt <= '0;
        quo  <= sat ? DIST_MAX : '0;
      end
      TU_DIVIDE: begin
        if (trial >= {1'b0, dv}) begin
          rem <= trial - {1'b0, dv};
          quo <= {quo[DIST_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[DIST_W-2:0], 1'b0};
        end
        lo   <= lo << 1;
        dcnt <= dcnt + 6'd1;
      end
      TU_DONE: begin
      end
      default: begin
      end
    endcase
  end
endmodule

### sv/dmc_checker.sv
// Port-level checker for the classifier and its bind.
`timescale 1ns / 1ps
`include "diagonal_mahalanobis_classifier_macros.svh"
module dmc_checker import dmc_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [1:0]  verdict,
  input logic [2:0]  match_count,
  input logic [2:0]  best_class
);
  // Hold a stalled result
  `DMC_ASSERT_NXT(a_hold, res_valid && !res_ready, res_valid)
  // Drop any result on reset
  `DMC_ASSERT_NXT_ALWAYS(a_reset, rst, !res_valid)
  // Verdict agrees with the match count
  `DMC_ASSERT_IMP(a_unknown, res_valid, (match_count == 3'd0) == (verdict == VERDICT_UNKNOWN))
  `DMC_ASSERT_IMP(a_ambig, res_valid && match_count > 3'd1, verdict == VERDICT_AMBIGUOUS)
  // A result with no accepted class reports class zero
  `DMC_ASSERT_IMP(a_noclass, res_valid && match_count == 3'd0, best_class == 3'd0)
endmodule

bind diagonal_mahalanobis_classifier dmc_checker u_dmc_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .verdict     (result.verdict),
  .match_count (result.match_count),
  .best_class  (result.best_class)
);

### verif/diagonal_mahalanobis_classifier_test.sv
// Self-checking testbench of the diagonal Mahalanobis classifier.
`timescale 1ns / 1ps
module diagonal_mahalanobis_classifier_test;
  import dmc_pkg::*;

  typedef struct {
    logic [0:0]         mode;
    logic [2:0]         class_index;
    logic [1:0]         feature_index;
    logic signed [39:0] mean_value;
    logic [47:0]        variance_value;
    logic signed [39:0] feat [NUM_FEATURES];
  } request_t;

  typedef struct {
    logic [1:0]        verdict;
    logic [2:0]        match_count;
    logic [2:0]        best_class;
    logic [DIST_W-1:0] best_distance;
  } verdict_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [0:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  dmc_req_if request ();
  dmc_rsp_if result ();

  diagonal_mahalanobis_classifier i_dut (
    .clk       (clk),
    .rst       (rst),
    .request   (request),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  request_t          pending_reqs [$];
  verdict_t          expected_verdicts [$];
  int                fail_count;
  logic              req_accepted;
  logic [DIST_W-1:0] threshold_reg;
  logic [BIAS_W-1:0] bias_reg;
  logic signed [39:0] mean_table [ENTRIES];
  logic [47:0]        variance_table [ENTRIES];
  // means as seen by the stimulus generator, in queue order
  logic signed [39:0] planned_mean [ENTRIES];

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  // One saturated term (x - mean)^2 / (var*(1+bias) + bias), Q32.16.
  function automatic logic [DIST_W-1:0] scaled_term(input logic signed [39:0] x,
                                                    input logic signed [39:0] mean,
                                                    input logic [47:0] vari);
    logic signed [40:0] diff;
    logic [40:0]        mag;
    logic [127:0]       num;
    logic [127:0]       den;
    logic [127:0]       quot;
    diff = {x[39], x} - {mean[39], mean};
    mag  = diff[40] ? -diff : diff;
    num  = (128'(mag) * 128'(mag)) << 16;
    den  = 128'(vari) * (128'(bias_reg) + 128'd65536) + (128'(bias_reg) << 16);
    if (den == 0) return DIST_MAX;
    quot = num / den;
    if (quot > 128'(DIST_MAX)) return DIST_MAX;
    return quot[DIST_W-1:0];
  endfunction

  // Apply one accepted request to the table or score it against every class.
  function automatic void score_request(input request_t req);
    verdict_t          v;
    logic [DIST_W:0]   sum;
    logic [DIST_W-1:0] best;
    int                count;
    int                k;
    if (req.mode == MODE_LOAD) begin
      if (req.class_index < NUM_CLASSES) begin
        k = req.class_index * NUM_FEATURES + req.feature_index;
        mean_table[k]     = req.mean_value;
        variance_table[k] = req.variance_value;
      end
      return;
    end
    best = threshold_reg;
    count = 0;
    v.best_class = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      sum = '0;
      for (int f = 0; f < NUM_FEATURES; f++) begin
        k = c * NUM_FEATURES + f;
        sum = sum + scaled_term(req.feat[f], mean_table[k], variance_table[k]);
        if (sum > DIST_MAX) sum = DIST_MAX;
      end
      if (sum[DIST_W-1:0] < threshold_reg) begin
        count++;
        if (sum[DIST_W-1:0] < best) begin
          best = sum[DIST_W-1:0];
          v.best_class = 3'(c);
        end
      end
    end
    v.verdict = count == 0 ? VERDICT_UNKNOWN :
                (count == 1 ? VERDICT_RECOGNIZED : VERDICT_AMBIGUOUS);
    v.match_count = 3'(count);
    v.best_distance = best;
    expected_verdicts.push_back(v);
  endfunction

  // Request driver: bursts of random length with random gaps.
  int burst_left;
  int gap_left;
  always @(negedge clk) begin
    if (rst) begin
      request.valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!request.valid || req_accepted) begin
      if (gap_left > 0 || pending_reqs.size() == 0) begin
        request.valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        request_t req;
        req = pending_reqs.pop_front();
        request.valid             <= 1'b1;
        request.mode              <= req.mode;
        request.class_index       <= req.class_index;
        request.feature_index     <= req.feature_index;
        request.mean_value        <= req.mean_value;
        request.variance_value    <= req.variance_value;
        request.feature_area      <= req.feat[0];
        request.feature_hu_first  <= req.feat[1];
        request.feature_hu_second <= req.feat[2];
        request.feature_perimeter <= req.feat[3];
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // Result receiver: own stall pattern plus one long hold-off.
  int rx_cycle;
  always @(negedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
      rx_cycle = 0;
    end else begin
      rx_cycle++;
      if (rx_cycle >= 30000 && rx_cycle < 38000)
        result.ready <= 1'b0;
      else if ((rx_cycle / 3000) % 3 == 0)
        result.ready <= 1'b1;
      else
        result.ready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Monitor: predict on accepted requests, check accepted results.
  always @(posedge clk) begin
    if (rst) begin
      req_accepted <= 1'b0;
    end else begin
      req_accepted <= request.valid && request.ready;
      if (request.valid && request.ready) begin
        request_t req;
        req.mode           = request.mode;
        req.class_index    = request.class_index;
        req.feature_index  = request.feature_index;
        req.mean_value     = request.mean_value;
        req.variance_value = request.variance_value;
        req.feat[0]        = request.feature_area;
        req.feat[1]        = request.feature_hu_first;
        req.feat[2]        = request.feature_hu_second;
        req.feat[3]        = request.feature_perimeter;
        score_request(req);
      end
      if (result.valid && result.ready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("result with no classify request pending");
        end else begin
          verdict_t v;
          v = expected_verdicts.pop_front();
          if (result.verdict !== v.verdict)
            report_mismatch($sformatf("verdict %0d, want %0d", result.verdict, v.verdict));
          if (result.match_count !== v.match_count)
            report_mismatch($sformatf("match_count %0d, want %0d",
                                      result.match_count, v.match_count));
          if (result.best_class !== v.best_class)
            report_mismatch($sformatf("best_class %0d, want %0d",
                                      result.best_class, v.best_class));
          if (result.best_distance !== v.best_distance)
            report_mismatch($sformatf("best_distance %0h, want %0h",
                                      result.best_distance, v.best_distance));
        end
      end
    end
  end

  task automatic add_load(input int cls, input int fe, input logic signed [39:0] mean,
                          input logic [47:0] vari);
    request_t req;
    req.mode = MODE_LOAD;
    req.class_index = 3'(cls);
    req.feature_index = 2'(fe);
    req.mean_value = mean;
    req.variance_value = vari;
    for (int f = 0; f < NUM_FEATURES; f++) req.feat[f] = 40'($urandom) ^ {$urandom, 8'h0};
    if (cls < NUM_CLASSES) planned_mean[cls * NUM_FEATURES + fe] = mean;
    pending_reqs.push_back(req);
  endtask

  task automatic add_classify(input logic signed [39:0] a, input logic signed [39:0] b,
                              input logic signed [39:0] c, input logic signed [39:0] d);
    request_t req;
    req.mode = MODE_CLASSIFY;
    req.class_index = 3'($urandom);
    req.feature_index = 2'($urandom);
    req.mean_value = {$urandom, 8'($urandom)};
    req.variance_value = {16'($urandom), $urandom};
    req.feat[0] = a;
    req.feat[1] = b;
    req.feat[2] = c;
    req.feat[3] = d;
    pending_reqs.push_back(req);
  endtask

  function automatic logic signed [39:0] near_mean(input int cls, input int fe);
    return planned_mean[cls * NUM_FEATURES + fe] + 40'($signed($urandom_range(0, 1 << 19)))
           - 40'sd262144;
  endfunction

  task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_THRESHOLD) threshold_reg = value[DIST_W-1:0];
    else bias_reg = value[BIAS_W-1:0];
  endtask

  // Hold until every request went in and every result came back.
  task automatic drain;
    wait (pending_reqs.size() == 0 && !request.valid);
    wait (expected_verdicts.size() == 0);
    repeat (50) @(posedge clk);
  endtask

  localparam logic signed [39:0] MEAN_MAX = 40'sh7FFFFFFFFF;
  localparam logic signed [39:0] MEAN_MIN = -40'sh8000000000;
  localparam logic [47:0]        VAR_MAX  = 48'hFFFFFFFFFFFF;

  initial begin
    logic [CFG_W-1:0] thr_set [4];
    logic [CFG_W-1:0] bias_set [4];
    int cls;
    fail_count = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_THRESHOLD;
    cfg_data = '0;
    request.valid = 1'b0;
    request.mode = MODE_LOAD;
    request.class_index = '0;
    request.feature_index = '0;
    request.mean_value = '0;
    request.variance_value = '0;
    request.feature_area = '0;
    request.feature_hu_first = '0;
    request.feature_hu_second = '0;
    request.feature_perimeter = '0;
    result.ready = 1'b0;
    threshold_reg = THRESHOLD_RESET;
    bias_reg = BIAS_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: fill every table entry, extremes in class 4
    for (int c = 0; c < NUM_CLASSES; c++)
      for (int f = 0; f < NUM_FEATURES; f++)
        add_load(c, f, (c == 4) ? ((f % 2) ? MEAN_MIN : MEAN_MAX)
                                : 40'(c * 4 + f) << 16,
                 (c == 4) ? ((f < 2) ? 48'd0 : VAR_MAX) : 48'(c) << 16);
    add_load(5, 1, MEAN_MAX, VAR_MAX);
    add_load(7, 3, MEAN_MIN, 48'd0);
    // exact match on class 0, exact match on class 2, extremes, opposite extremes
    add_classify(40'd0, 40'd65536, 40'd131072, 40'd196608);
    add_classify(40'd8 << 16, 40'd9 << 16, 40'd10 << 16, 40'd11 << 16);
    add_classify(MEAN_MAX, MEAN_MIN, MEAN_MAX, MEAN_MIN);
    add_classify(MEAN_MIN, MEAN_MAX, MEAN_MIN, MEAN_MAX);
    drain();

    thr_set = '{48'd870122, 48'd0, 48'hFFFFFFFFFFFF, 48'd0};
    bias_set = '{32'd131072, 32'd0, 32'hFFFFFFFF, 32'd0};
    thr_set[3] = {16'($urandom_range(0, 3)), $urandom};
    bias_set[3] = $urandom_range(0, 1 << 18);

    for (int phase = 0; phase < 4; phase++) begin
      write_reg(REG_THRESHOLD, thr_set[phase]);
      write_reg(REG_BIAS, 48'(bias_set[phase]));
      for (int n = 0; n < 140; n++) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6: begin
            cls = $urandom_range(0, NUM_CLASSES - 1);
            add_classify(near_mean(cls, 0), near_mean(cls, 1), near_mean(cls, 2),
                         near_mean(cls, 3));
          end
          7, 8:
            add_classify({$urandom, 8'($urandom)}, {$urandom, 8'($urandom)},
                         {$urandom, 8'($urandom)}, {$urandom, 8'($urandom)});
          9, 10:
            add_load($urandom_range(0, 7), $urandom_range(0, 3),
                     {$urandom, 8'($urandom)}, {16'($urandom), $urandom});
          default:
            add_load($urandom_range(0, NUM_CLASSES - 1), $urandom_range(0, 3),
                     40'($signed($urandom_range(0, 1 << 31))) - 40'sd1073741824,
                     48'($urandom_range(0, 1 << 20)));
        endcase
      end
      drain();
    end

    repeat (1500) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Run limit
  initial begin
    #40ms;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
